@@ hdl/lrmp_pkg.sv @@
// Shared constants, state codes and address map for the recurrence matrix-power unit.
// No dependencies.
package lrmp_pkg;

  localparam int unsigned VALUE_BITS_DEF = 20;
  localparam int unsigned INDEX_BITS_DEF = 31;
  localparam int unsigned MODULUS_RESET  = 666013;

  // Scratch memory: banks of 9 matrix cells at 0, 9, 18; start terms at 27..29.
  localparam int unsigned MEM_DEPTH = 32;
  localparam int unsigned ADDR_W    = 5;
  localparam logic [ADDR_W-1:0] F_ADDR = ADDR_W'(27);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_RED,
    S_RED_W,
    S_SRD,
    S_SLD,
    S_LOOP,
    S_MRD,
    S_MLD,
    S_MWT,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    MODE_ACC,
    MODE_SQR,
    MODE_DOT
  } mode_e;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [1:0] bank,
                                                  input logic [1:0] row,
                                                  input logic [1:0] col);
    cell_addr = ADDR_W'(bank) * ADDR_W'(9) + ADDR_W'(row) * ADDR_W'(3) + ADDR_W'(col);
  endfunction

endpackage

@@ hdl/lrmp_mem.sv @@
// Scratch memory for matrix banks and start terms: one write port, two read ports,
// registered read data. Depends on lrmp_pkg.
module lrmp_mem #(
  parameter int unsigned VALUE_BITS = lrmp_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [lrmp_pkg::ADDR_W-1:0]   waddr_i,
  input  logic [VALUE_BITS-1:0]         wdata_i,
  input  logic [lrmp_pkg::ADDR_W-1:0]   raddr_a_i,
  input  logic [lrmp_pkg::ADDR_W-1:0]   raddr_b_i,
  output logic [VALUE_BITS-1:0]         rdata_a_o,
  output logic [VALUE_BITS-1:0]         rdata_b_o
);
  import lrmp_pkg::*;

  logic [VALUE_BITS-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

@@ hdl/lrmp_modmul.sv @@
// Bit-serial modular multiplier: (x * y) mod m, one bit of y per cycle, MSB first.
// Operand x must already be below m. Depends on lrmp_pkg.
module lrmp_modmul #(
  parameter int unsigned VALUE_BITS = lrmp_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] x_i,
  input  logic [VALUE_BITS-1:0] y_i,
  input  logic [VALUE_BITS-1:0] m_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] p_o
);
  import lrmp_pkg::*;

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] r_q, r_d, x_q, y_q, y_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d, done_q, done_d;
  logic [VALUE_BITS:0]   dbl, dbl_red, sum;

  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    sum     = dbl_red + {1'b0, x_q};
    if (y_q[VALUE_BITS-1]) begin
      sum = (sum >= {1'b0, m_i}) ? sum - {1'b0, m_i} : sum;
    end else begin
      sum = dbl_red;
    end
    r_d    = r_q;
    y_d    = y_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      r_d    = '0;
      y_d    = y_i;
      cnt_d  = CNT_W'(VALUE_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = sum[VALUE_BITS-1:0];
      y_d   = {y_q[VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    y_q <= y_d;
    if (start_i) begin
      x_q <= x_i;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign p_o    = r_q;

endmodule

@@ hdl/linear_recurrence_matrix_power_mod_unit.sv @@
// Work per item: P = popcount(n-2) + bitlen(n-2) - 1 matrix products (none for n = 2), each
// multiply-accumulate going through the single bit-serial modular multiplier.
// One item at a time; the next item is taken the cycle after the result is loaded, also
// while that result still waits on the output register.
// Reset: async active-low, modulus returns to 666013, control idle, memory not cleared.
module linear_recurrence_matrix_power_mod_unit #(
  parameter int unsigned VALUE_BITS = lrmp_pkg::VALUE_BITS_DEF,
  parameter int unsigned INDEX_BITS = lrmp_pkg::INDEX_BITS_DEF,
  localparam int unsigned IN_W  = ((6 * VALUE_BITS + INDEX_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [VALUE_BITS-1:0] cfg_data_i,   // modulus
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // term_zero, term_one, term_two, coef_a, coef_b, coef_c, term_index
  input  logic [IN_W-1:0]       s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata  // term_value
);
  import lrmp_pkg::*;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;

  logic [VALUE_BITS-1:0] mod_q, m_eff, one_v;
  logic [VALUE_BITS-1:0] vals_q [6];
  logic [INDEX_BITS-1:0] n_q, e_q, e_d;
  logic [1:0]  abank_q, abank_d, bbank_q, bbank_d, fbank;
  logic [1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [4:0]  clr_q, clr_d;
  logic [2:0]  red_q, red_d;
  logic [VALUE_BITS-1:0] racc_q, racc_d, res_q, res_d, out_q;
  logic        out_valid_q;
  logic        out_load;
  logic [VALUE_BITS:0] acc_sum;

  logic                  we;
  logic [ADDR_W-1:0]     waddr, raddr_a, raddr_b;
  logic [VALUE_BITS-1:0] wdata, rdata_a, rdata_b;

  logic                  mm_start, mm_busy, mm_done;
  logic [VALUE_BITS-1:0] mm_x, mm_y, mm_p;

  assign m_eff = (mod_q == '0) ? VALUE_BITS'(1) : mod_q;
  assign one_v = (mod_q <= VALUE_BITS'(1)) ? '0 : VALUE_BITS'(1);
  assign fbank = 2'd3 - abank_q - bbank_q;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_q);

  lrmp_mem #(.VALUE_BITS(VALUE_BITS)) u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  lrmp_modmul #(.VALUE_BITS(VALUE_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .x_i     (mm_x),
    .y_i     (mm_y),
    .m_i     (m_eff),
    .busy_o  (mm_busy),
    .done_o  (mm_done),
    .p_o     (mm_p)
  );

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    e_d      = e_q;
    abank_d  = abank_q;
    bbank_d  = bbank_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    clr_d    = clr_q;
    red_d    = red_q;
    racc_d   = racc_q;
    res_d    = res_q;
    out_load = 1'b0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    raddr_a  = '0;
    raddr_b  = '0;
    mm_start = 1'b0;
    mm_x     = rdata_a;
    mm_y     = rdata_b;
    acc_sum  = {1'b0, racc_q} + {1'b0, mm_p};
    if (acc_sum >= {1'b0, m_eff}) begin
      acc_sum = acc_sum - {1'b0, m_eff};
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          clr_d   = '0;
          abank_d = 2'd1;
          bbank_d = 2'd0;
          state_d = S_CLR;
        end
      end
      // constant cells of base (bank 0) and identity (bank 1)
      S_CLR: begin
        we    = 1'b1;
        waddr = ADDR_W'(clr_q);
        if (clr_q == 5'd3 || clr_q == 5'd7 || clr_q == 5'd9 || clr_q == 5'd13 ||
            clr_q == 5'd17) begin
          wdata = one_v;
        end
        clr_d = clr_q + 5'd1;
        if (clr_q == 5'd17) begin
          red_d   = '0;
          state_d = S_RED;
        end
      end
      // reduce f0, f1, f2, a, b, c as 1 * v mod m
      S_RED: begin
        mm_start = 1'b1;
        mm_x     = one_v;
        mm_y     = vals_q[red_q];
        state_d  = S_RED_W;
      end
      S_RED_W: begin
        if (mm_done) begin
          we    = 1'b1;
          wdata = mm_p;
          waddr = (red_q < 3'd3) ? F_ADDR + ADDR_W'(red_q) : ADDR_W'(red_q - 3'd3);
          red_d = red_q + 3'd1;
          if (red_q != 3'd5) begin
            state_d = S_RED;
          end else if (n_q < INDEX_BITS'(2)) begin
            state_d = S_SRD;
          end else begin
            e_d     = n_q - INDEX_BITS'(2);
            state_d = S_LOOP;
          end
        end
      end
      S_SRD: begin
        raddr_b = F_ADDR + ADDR_W'(n_q[0]);
        state_d = S_SLD;
      end
      S_SLD: begin
        res_d   = rdata_b;
        state_d = S_DONE;
      end
      S_LOOP: begin
        i_d    = '0;
        j_d    = '0;
        k_d    = '0;
        racc_d = '0;
        if (e_q == '0) begin
          mode_d = MODE_DOT;
        end else if (e_q[0]) begin
          mode_d = MODE_ACC;
        end else begin
          mode_d = MODE_SQR;
        end
        state_d = S_MRD;
      end
      S_MRD: begin
        case (mode_q)
          MODE_ACC: begin
            raddr_a = cell_addr(abank_q, i_q, k_q);
            raddr_b = cell_addr(bbank_q, k_q, j_q);
          end
          MODE_SQR: begin
            raddr_a = cell_addr(bbank_q, i_q, k_q);
            raddr_b = cell_addr(bbank_q, k_q, j_q);
          end
          default: begin
            raddr_a = cell_addr(abank_q, 2'd0, k_q);
            raddr_b = F_ADDR + ADDR_W'(2'd2 - k_q);
          end
        endcase
        state_d = S_MLD;
      end
      S_MLD: begin
        mm_start = 1'b1;
        state_d  = S_MWT;
      end
      S_MWT: begin
        if (mm_done) begin
          racc_d  = acc_sum[VALUE_BITS-1:0];
          state_d = S_MRD;
          k_d     = k_q + 2'd1;
          if (k_q == 2'd2) begin
            k_d    = '0;
            racc_d = '0;
            if (mode_q == MODE_DOT) begin
              res_d   = acc_sum[VALUE_BITS-1:0];
              state_d = S_DONE;
            end else begin
              we    = 1'b1;
              waddr = cell_addr(fbank, i_q, j_q);
              wdata = acc_sum[VALUE_BITS-1:0];
              j_d   = j_q + 2'd1;
              if (j_q == 2'd2) begin
                j_d = '0;
                i_d = i_q + 2'd1;
                if (i_q == 2'd2) begin
                  state_d = S_LOOP;
                  if (mode_q == MODE_ACC) begin
                    abank_d = fbank;
                    if (e_q == INDEX_BITS'(1)) begin
                      e_d = '0;
                    end else begin
                      e_d = {e_q[INDEX_BITS-1:1], 1'b0};
                    end
                  end else begin
                    bbank_d = fbank;
                    e_d     = e_q >> 1;
                  end
                end
              end
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_DOT;
      mod_q       <= VALUE_BITS'(MODULUS_RESET);
      out_valid_q <= 1'b0;
      e_q         <= '0;
      abank_q     <= 2'd1;
      bbank_q     <= 2'd0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      clr_q       <= '0;
      red_q       <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      e_q     <= e_d;
      abank_q <= abank_d;
      bbank_q <= bbank_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      clr_q   <= clr_d;
      red_q   <= red_d;
      if (cfg_valid_i) begin
        mod_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    racc_q <= racc_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      for (int f = 0; f < 6; f++) begin
        vals_q[f] <= s_axis_tdata[f*VALUE_BITS +: VALUE_BITS];
      end
      n_q <= s_axis_tdata[6*VALUE_BITS +: INDEX_BITS];
    end
  end

  // the multiplier is only started when idle
  a_mm_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_start |-> !mm_busy) else $error("multiplier restarted while busy");

  // product results never land in a bank being read
  a_wr_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && state_q == S_MWT) |-> (fbank != abank_q && fbank != bbank_q && fbank != 2'd3))
    else $error("product written over a live bank");

  // a new result is always reduced below the modulus
  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_q < m_eff) else $error("result not reduced");

endmodule

@@ verif/tb_linear_recurrence_matrix_power_mod_unit.sv @@
// Testbench for linear_recurrence_matrix_power_mod_unit: random and directed queries are
// checked against a matrix-power predictor held in a small scoreboard class.
// Depends on lrmp_pkg and the unit itself.
module tb_linear_recurrence_matrix_power_mod_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VB    = lrmp_pkg::VALUE_BITS_DEF;
  localparam int unsigned IB    = lrmp_pkg::INDEX_BITS_DEF;
  localparam int unsigned IN_W  = ((6 * VB + IB + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((VB + 7) / 8) * 8;
  localparam int unsigned STALL_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 30000;

  typedef struct {
    bit [VB-1:0] f0, f1, f2, ca, cb, cc;
    bit [IB-1:0] n;
  } query_t;

  typedef longint unsigned mat3_t [3][3];

  class term_scoreboard;
    bit [VB-1:0] pending_terms[$];
    int unsigned errors;

    function mat3_t mat_mul(mat3_t x, mat3_t y, longint unsigned m);
      mat3_t r;
      longint unsigned s;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s = 0;
          for (int k = 0; k < 3; k++) s = (s + x[i][k] * y[k][j]) % m;
          r[i][j] = s;
        end
      end
      return r;
    endfunction

    // f(n) by raising the companion matrix to n-2
    function bit [VB-1:0] recurrence_term(query_t q, bit [VB-1:0] modv);
      longint unsigned m, f0, f1, f2, e, r;
      mat3_t base, pw;
      m  = (modv == 0) ? 1 : modv;
      f0 = q.f0 % m;
      f1 = q.f1 % m;
      f2 = q.f2 % m;
      if (q.n == 0) return VB'(f0);
      if (q.n == 1) return VB'(f1);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          base[i][j] = 0;
          pw[i][j]   = (i == j) ? 1 % m : 0;
        end
      base[0][0] = q.ca % m;
      base[0][1] = q.cb % m;
      base[0][2] = q.cc % m;
      base[1][0] = 1 % m;
      base[2][1] = 1 % m;
      e = q.n - 2;
      while (e != 0) begin
        if (e[0]) pw = mat_mul(pw, base, m);
        base = mat_mul(base, base, m);
        e >>= 1;
      end
      r = (pw[0][0] * f2) % m;
      r = (r + pw[0][1] * f1) % m;
      r = (r + pw[0][2] * f0) % m;
      return VB'(r);
    endfunction

    function void note_query(query_t q, bit [VB-1:0] modv);
      pending_terms.push_back(recurrence_term(q, modv));
    endfunction

    function void check_term(bit [VB-1:0] actual);
      bit [VB-1:0] exp_v;
      if (pending_terms.size() == 0) begin
        $error("term_value: unexpected item, actual %0d", actual);
        errors++;
        return;
      end
      exp_v = pending_terms.pop_front();
      if (exp_v !== actual) begin
        $error("term_value: expected %0d, actual %0d", exp_v, actual);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [VB-1:0]    cfg_data_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  term_scoreboard sb;
  bit [VB-1:0]    cur_modulus;
  int unsigned    send_idle;
  int unsigned    recv_idle;
  bit             hold_req;
  int unsigned    hold_left;
  int unsigned    quiet_cycles;

  linear_recurrence_matrix_power_mod_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // receiver: random stalls, or one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_term(m_axis_tdata[VB-1:0]);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("linear_recurrence_matrix_power_mod_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_query(query_t q);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({q.n, q.cc, q.cb, q.ca, q.f2, q.f1, q.f0});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_query(q, cur_modulus);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_terms.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_modulus(bit [VB-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_modulus = value;
  endtask

  // mostly tiny indices: a full-width index needs the most matrix products
  function automatic bit [IB-1:0] pick_index();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return IB'($urandom_range(32'h7fff_ffff, 2));
    if (r < 10) return IB'($urandom_range(1023, 2));
    return IB'($urandom_range(10, 2));
  endfunction

  function automatic bit [VB-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return VB'(cur_modulus - 1);
      default: return VB'($urandom);
    endcase
  endfunction

  task automatic random_queries(int unsigned count);
    query_t q;
    for (int i = 0; i < count; i++) begin
      q.f0 = pick_value();
      q.f1 = pick_value();
      q.f2 = pick_value();
      q.ca = pick_value();
      q.cb = pick_value();
      q.cc = pick_value();
      q.n  = pick_index();
      send_query(q);
    end
  endtask

  task automatic directed_queries();
    query_t q;
    bit [VB-1:0] ones;
    ones = '1;
    q = '{ones, ones, ones, ones, ones, ones, IB'(2)};
    send_query(q);
    q.n = IB'(3);
    send_query(q);
    q.n = '1;
    send_query(q);
    q = '{'0, '0, '0, '0, '0, '0, IB'(2)};
    send_query(q);
    q.n = '1;
    send_query(q);
    // Tribonacci-like: 0,1,1 weights 1,1,1
    q = '{VB'(0), VB'(1), VB'(1), VB'(1), VB'(1), VB'(1), IB'(37)};
    send_query(q);
    q.n = IB'(1) << (IB - 1);
    send_query(q);
    q = '{VB'(5), VB'(7), VB'(11), VB'(666013), VB'(666012), VB'(0), IB'(4)};
    send_query(q);
    q = '{VB'(1), VB'(0), VB'(0), VB'(0), VB'(0), VB'(1), IB'(5)};
    send_query(q);
    q = '{VB'(3), VB'(0), VB'(0), VB'(0), VB'(0), VB'(2), IB'(8)};
    send_query(q);
    q = '{VB'(123456), VB'(654321), VB'(999999), VB'(2), VB'(3), VB'(4), IB'(1000)};
    send_query(q);
    q = '{VB'('h55555), VB'('haaaaa), VB'('h55555), VB'('haaaaa), VB'('h55555),
          VB'('haaaaa), IB'('h2aaa_aaaa)};
    send_query(q);
  endtask

  initial begin
    sb            = new;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cur_modulus   = VB'(lrmp_pkg::MODULUS_RESET);
    send_idle     = 30;
    recv_idle     = 73;
    hold_req      = 1'b0;
    hold_left     = 0;
    quiet_cycles  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_queries();
    random_queries(15);
    drain();
    write_modulus('1);
    directed_queries();
    random_queries(30);
    drain();
    write_modulus(VB'(2));
    random_queries(20);
    drain();

    send_idle = 73;
    recv_idle = 30;
    // modulus zero behaves as one
    write_modulus('0);
    random_queries(12);
    drain();
    write_modulus(VB'(1));
    random_queries(12);
    drain();
    write_modulus(VB'($urandom_range(1048575, 2)));
    random_queries(50);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_modulus(VB'($urandom_range(1048575, 2)));
    hold_req = 1'b1;
    random_queries(60);
    drain();
    write_modulus(VB'(lrmp_pkg::MODULUS_RESET));
    random_queries(55);
    drain();
    repeat (200) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_terms.size() == 0) begin
      $display("linear_recurrence_matrix_power_mod_unit: match");
    end else begin
      $display("linear_recurrence_matrix_power_mod_unit: mismatch");
    end
    $finish;
  end

endmodule
